// File: hw/rtl/vdhs_pkg.sv
// Shared types, constants and helper functions for the vehicle depth, heading and speed controller.
package vdhs_pkg;

    localparam int POS_BITS_DEF   = 32;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int MA_W  = 40;
    localparam int MB_W  = 20;
    localparam int MP_W  = MA_W + MB_W;
    localparam int ACC_W = MP_W + 2;

    localparam int PI_Q16   = 205887;
    localparam int TS_Q16   = 3277;
    localparam int SUM_LIM  = 327680;
    localparam int DEFL_LIM = 5120;
    localparam int RPM_MIN  = 400;
    localparam int RPM_MAX  = 1500;
    localparam int SIN_C1   = 102944;
    localparam int SIN_C2   = 42048;
    localparam int SIN_C3   = 4640;

    localparam logic [47:0] ELEV_GAINS_RST  = 48'd5497558141184;
    localparam logic [47:0] RUD_GAINS_RST   = 48'd1099511628288;
    localparam logic [47:0] PROP_GAINS_RST  = 48'd3298539929907;
    localparam logic [31:0] GUIDE_GAINS_RST = 32'd16784896;

    typedef enum logic [1:0] {
        CFG_ELEVATOR  = 2'd0,
        CFG_RUDDER    = 2'd1,
        CFG_PROPELLER = 2'd2,
        CFG_GUIDANCE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_Z,
        ST_Z2,
        ST_IN,
        ST_MID,
        ST_S,
        ST_PSI,
        ST_XR1,
        ST_XR2,
        ST_XR3,
        ST_YR2,
        ST_YR3,
        ST_VD,
        ST_HD,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_FIN
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        else
        begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [MB_W-1:0] gain_b(input logic [15:0] g);
        return $signed({{(MB_W-16){1'b0}}, g});
    endfunction

endpackage

// File: hw/rtl/vdhs_mul.sv
// Shared signed multiplier with a registered product.
module vdhs_mul (
    input  logic                           clk,
    input  logic signed [vdhs_pkg::MA_W-1:0] a,
    input  logic signed [vdhs_pkg::MB_W-1:0] b,
    output logic signed [vdhs_pkg::MP_W-1:0] p
);
    import vdhs_pkg::*;

    logic signed [MP_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/vehicle_depth_heading_speed_pid.sv
// Top level of the vehicle depth, heading and speed PID controller.
// One transaction runs from acceptance to the output register, all on one shared
// multiplier: 10 steps of sine and cosine, 8 steps of yaw scaling, rotation and guidance,
// 5 steps per PID loop and one step that loads the output register.
// A new transaction is taken in the cycle after the previous one has reached the output
// register; a stalled output holds the block in its last step.
// Reset loads the default gains, clears all integrals and previous errors, and empties the output.
module vehicle_depth_heading_speed_pid #(
    parameter int POS_BITS   = vdhs_pkg::POS_BITS_DEF,
    parameter int ANGLE_BITS = vdhs_pkg::ANGLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [47:0]                  cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [POS_BITS-1:0]   depth_now,
    input  logic signed [ANGLE_BITS-1:0] yaw_now,
    input  logic signed [POS_BITS-1:0]   pos_x_now,
    input  logic signed [POS_BITS-1:0]   pos_y_now,
    input  logic signed [POS_BITS-1:0]   depth_target,
    input  logic signed [POS_BITS-1:0]   pos_x_target,
    input  logic signed [POS_BITS-1:0]   pos_y_target,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [13:0]           elevator_cmd,
    output logic signed [13:0]           rudder_cmd,
    output logic [10:0]                  propeller_rpm
);
    import vdhs_pkg::*;

    state_t state_reg, state_next;
    logic   sc_reg, sc_next;
    logic [1:0] lp_reg, lp_next;
    logic   out_valid_reg, out_valid_next;
    logic [47:0] elev_gains_reg, elev_gains_next;
    logic [47:0] rud_gains_reg, rud_gains_next;
    logic [47:0] prop_gains_reg, prop_gains_next;
    logic [31:0] guide_gains_reg, guide_gains_next;
    logic signed [31:0] depth_last_reg, depth_last_next, depth_sum_reg, depth_sum_next;
    logic signed [31:0] head_last_reg, head_last_next, head_sum_reg, head_sum_next;
    logic signed [31:0] speed_last_reg, speed_last_next, speed_sum_reg, speed_sum_next;

    logic signed [31:0] ex_reg, ex_next, ey_reg, ey_next, ez_reg, ez_next;
    logic signed [ANGLE_BITS-1:0] yaw_reg, yaw_next;
    logic [15:0] ang_reg, ang_next;
    logic [1:0]  q_reg, q_next;
    logic signed [17:0] z_reg, z_next, z2_reg, z2_next, sn_reg, sn_next, cs_reg, cs_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0] psi_reg, psi_next, xr_reg, xr_next, yr_reg, yr_next;
    logic signed [31:0] vdes_reg, vdes_next, eh_reg, eh_next, s_reg, s_next;
    logic signed [13:0] elev_res_reg, elev_res_next, rud_res_reg, rud_res_next;
    logic [10:0] rpm_res_reg, rpm_res_next;
    logic signed [13:0] elev_out_reg, elev_out_next, rud_out_reg, rud_out_next;
    logic [10:0] rpm_out_reg, rpm_out_next;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;

    logic signed [POS_BITS:0] dx, dy, dz;

    logic [ANGLE_BITS+15:0] ang_wide;
    logic signed [31:0] pid_e, pid_last, pid_sum;
    logic [47:0] pid_gains;
    logic [15:0] sang;
    logic [14:0] fm;
    logic signed [19:0] tmp20;
    logic signed [17:0] s18;
    logic signed [ACC_W-1:0] tmp_acc, outv, sh, mag;
    logic signed [63:0] tmp64;
    logic signed [31:0] psides;
    logic signed [MA_W-1:0] dd, d20;

    vdhs_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign dx = (POS_BITS+1)'(pos_x_target) - (POS_BITS+1)'(pos_x_now);
    assign dy = (POS_BITS+1)'(pos_y_target) - (POS_BITS+1)'(pos_y_now);
    assign dz = (POS_BITS+1)'(depth_target) - (POS_BITS+1)'(depth_now);
    assign ang_wide = {yaw_now, 16'b0};

    always_comb
    begin
        case (lp_reg)
            2'd0:
            begin
                pid_e = ez_reg; pid_last = depth_last_reg; pid_sum = depth_sum_reg;
                pid_gains = elev_gains_reg;
            end
            2'd1:
            begin
                pid_e = eh_reg; pid_last = head_last_reg; pid_sum = head_sum_reg;
                pid_gains = rud_gains_reg;
            end
            default:
            begin
                pid_e = vdes_reg; pid_last = speed_last_reg; pid_sum = speed_sum_reg;
                pid_gains = prop_gains_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        sc_next = sc_reg;
        lp_next = lp_reg;
        out_valid_next = out_valid_reg;
        elev_gains_next = elev_gains_reg;
        rud_gains_next = rud_gains_reg;
        prop_gains_next = prop_gains_reg;
        guide_gains_next = guide_gains_reg;
        depth_last_next = depth_last_reg;
        depth_sum_next = depth_sum_reg;
        head_last_next = head_last_reg;
        head_sum_next = head_sum_reg;
        speed_last_next = speed_last_reg;
        speed_sum_next = speed_sum_reg;
        ex_next = ex_reg;
        ey_next = ey_reg;
        ez_next = ez_reg;
        yaw_next = yaw_reg;
        ang_next = ang_reg;
        q_next = q_reg;
        z_next = z_reg;
        z2_next = z2_reg;
        sn_next = sn_reg;
        cs_next = cs_reg;
        acc_next = acc_reg;
        psi_next = psi_reg;
        xr_next = xr_reg;
        yr_next = yr_reg;
        vdes_next = vdes_reg;
        eh_next = eh_reg;
        s_next = s_reg;
        elev_res_next = elev_res_reg;
        rud_res_next = rud_res_reg;
        rpm_res_next = rpm_res_reg;
        elev_out_next = elev_out_reg;
        rud_out_next = rud_out_reg;
        rpm_out_next = rpm_out_reg;
        mul_a = '0;
        mul_b = '0;
        sang = '0;
        fm = '0;
        tmp20 = '0;
        s18 = '0;
        tmp_acc = '0;
        outv = '0;
        sh = '0;
        mag = '0;
        tmp64 = '0;
        psides = '0;
        dd = '0;
        d20 = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ELEVATOR:  elev_gains_next = cfg_wdata;
                CFG_RUDDER:    rud_gains_next = cfg_wdata;
                CFG_PROPELLER: prop_gains_next = cfg_wdata;
                CFG_GUIDANCE:  guide_gains_next = cfg_wdata[31:0];
                default:       guide_gains_next = guide_gains_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ex_next = sat32(64'(dx));
                    ey_next = sat32(64'(dy));
                    ez_next = sat32(64'(dz));
                    yaw_next = yaw_now;
                    ang_next = ang_wide[ANGLE_BITS+15:ANGLE_BITS];
                    sc_next = 1'b0;
                    state_next = ST_Z;
                end
            end
            ST_Z:
            begin
                sang = sc_reg ? ang_reg + 16'h4000 : ang_reg;
                fm = sang[14] ? 15'd16384 - {1'b0, sang[13:0]} : {1'b0, sang[13:0]};
                z_next = $signed({1'b0, fm, 2'b00});
                q_next = sang[15:14];
                mul_a = MA_W'(z_next);
                mul_b = MB_W'(z_next);
                state_next = ST_Z2;
            end
            ST_Z2:
            begin
                z2_next = 18'(mul_p >>> 16);
                mul_a = MA_W'(SIN_C3);
                mul_b = MB_W'(z2_next);
                state_next = ST_IN;
            end
            ST_IN:
            begin
                tmp20 = 20'(SIN_C2) - 20'(mul_p >>> 16);
                mul_a = MA_W'(z2_reg);
                mul_b = tmp20;
                state_next = ST_MID;
            end
            ST_MID:
            begin
                tmp20 = 20'(SIN_C1) - 20'(mul_p >>> 16);
                mul_a = MA_W'(z_reg);
                mul_b = tmp20;
                state_next = ST_S;
            end
            ST_S:
            begin
                s18 = 18'(mul_p >>> 16);
                if (q_reg[1])
                begin
                    s18 = -s18;
                end
                if (!sc_reg)
                begin
                    sn_next = s18;
                    sc_next = 1'b1;
                    state_next = ST_Z;
                end
                else
                begin
                    cs_next = s18;
                    state_next = ST_PSI;
                end
            end
            ST_PSI:
            begin
                mul_a = MA_W'(yaw_reg);
                mul_b = MB_W'(PI_Q16);
                state_next = ST_XR1;
            end
            ST_XR1:
            begin
                psi_next = 32'(mul_p >>> (ANGLE_BITS - 1));
                mul_a = MA_W'(ex_reg);
                mul_b = MB_W'(cs_reg);
                state_next = ST_XR2;
            end
            ST_XR2:
            begin
                acc_next = ACC_W'(mul_p);
                mul_a = MA_W'(ey_reg);
                mul_b = MB_W'(sn_reg);
                state_next = ST_XR3;
            end
            ST_XR3:
            begin
                tmp_acc = acc_reg - ACC_W'(mul_p);
                xr_next = sat32(64'(tmp_acc >>> 16));
                mul_a = MA_W'(ex_reg);
                mul_b = MB_W'(sn_reg);
                state_next = ST_YR2;
            end
            ST_YR2:
            begin
                acc_next = ACC_W'(mul_p);
                mul_a = MA_W'(ey_reg);
                mul_b = MB_W'(cs_reg);
                state_next = ST_YR3;
            end
            ST_YR3:
            begin
                tmp_acc = acc_reg + ACC_W'(mul_p);
                yr_next = sat32(64'(tmp_acc >>> 16));
                mul_a = xr_reg[31] ? -MA_W'(xr_reg) : MA_W'(xr_reg);
                mul_b = gain_b(guide_gains_reg[15:0]);
                state_next = ST_VD;
            end
            ST_VD:
            begin
                vdes_next = sat32(64'(mul_p >>> 8));
                mul_a = MA_W'(yr_reg);
                mul_b = gain_b(guide_gains_reg[31:16]);
                state_next = ST_HD;
            end
            ST_HD:
            begin
                psides = sat32(64'(mul_p >>> 8));
                tmp64 = 64'(psides) - 64'(psi_reg);
                eh_next = sat32(tmp64);
                lp_next = 2'd0;
                state_next = ST_P0;
            end
            ST_P0:
            begin
                mul_a = MA_W'(pid_e);
                mul_b = MB_W'(TS_Q16);
                state_next = ST_P1;
            end
            ST_P1:
            begin
                tmp64 = 64'(pid_sum) + 64'(mul_p >>> 16);
                if (tmp64 > 64'(SUM_LIM))
                begin
                    s_next = 32'(SUM_LIM);
                end
                else if (tmp64 < -64'(SUM_LIM))
                begin
                    s_next = -32'(SUM_LIM);
                end
                else
                begin
                    s_next = tmp64[31:0];
                end
                case (lp_reg)
                    2'd0:    depth_sum_next = s_next;
                    2'd1:    head_sum_next = s_next;
                    default: speed_sum_next = s_next;
                endcase
                mul_a = MA_W'(pid_e);
                mul_b = gain_b(pid_gains[15:0]);
                state_next = ST_P2;
            end
            ST_P2:
            begin
                acc_next = ACC_W'(mul_p);
                mul_a = MA_W'(s_reg);
                mul_b = gain_b(pid_gains[31:16]);
                state_next = ST_P3;
            end
            ST_P3:
            begin
                acc_next = acc_reg + ACC_W'(mul_p);
                dd = MA_W'(pid_e) - MA_W'(pid_last);
                d20 = (dd <<< 4) + (dd <<< 2);
                mul_a = d20;
                mul_b = gain_b(pid_gains[47:32]);
                state_next = ST_P4;
            end
            ST_P4:
            begin
                outv = acc_reg + ACC_W'(mul_p);
                sh = outv >>> 16;
                case (lp_reg)
                    2'd0:
                    begin
                        sh = -sh;
                        if (sh > ACC_W'(DEFL_LIM))
                        begin
                            elev_res_next = 14'(DEFL_LIM);
                        end
                        else if (sh < -ACC_W'(DEFL_LIM))
                        begin
                            elev_res_next = -14'(DEFL_LIM);
                        end
                        else
                        begin
                            elev_res_next = sh[13:0];
                        end
                        depth_last_next = pid_e;
                    end
                    2'd1:
                    begin
                        if (sh > ACC_W'(DEFL_LIM))
                        begin
                            rud_res_next = 14'(DEFL_LIM);
                        end
                        else if (sh < -ACC_W'(DEFL_LIM))
                        begin
                            rud_res_next = -14'(DEFL_LIM);
                        end
                        else
                        begin
                            rud_res_next = sh[13:0];
                        end
                        head_last_next = pid_e;
                    end
                    default:
                    begin
                        mag = outv[ACC_W-1] ? -outv : outv;
                        mag = mag >>> 24;
                        if (mag > ACC_W'(RPM_MAX))
                        begin
                            rpm_res_next = 11'(RPM_MAX);
                        end
                        else if (mag < ACC_W'(RPM_MIN))
                        begin
                            rpm_res_next = 11'(RPM_MIN);
                        end
                        else
                        begin
                            rpm_res_next = mag[10:0];
                        end
                        speed_last_next = pid_e;
                    end
                endcase
                if (lp_reg == 2'd2)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    lp_next = lp_reg + 2'd1;
                    state_next = ST_P0;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    elev_out_next = elev_res_reg;
                    rud_out_next = rud_res_reg;
                    rpm_out_next = rpm_res_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sc_reg <= 1'b0;
            lp_reg <= 2'd0;
            out_valid_reg <= 1'b0;
            elev_gains_reg <= ELEV_GAINS_RST;
            rud_gains_reg <= RUD_GAINS_RST;
            prop_gains_reg <= PROP_GAINS_RST;
            guide_gains_reg <= GUIDE_GAINS_RST;
            depth_last_reg <= '0;
            depth_sum_reg <= '0;
            head_last_reg <= '0;
            head_sum_reg <= '0;
            speed_last_reg <= '0;
            speed_sum_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg <= sc_next;
            lp_reg <= lp_next;
            out_valid_reg <= out_valid_next;
            elev_gains_reg <= elev_gains_next;
            rud_gains_reg <= rud_gains_next;
            prop_gains_reg <= prop_gains_next;
            guide_gains_reg <= guide_gains_next;
            depth_last_reg <= depth_last_next;
            depth_sum_reg <= depth_sum_next;
            head_last_reg <= head_last_next;
            head_sum_reg <= head_sum_next;
            speed_last_reg <= speed_last_next;
            speed_sum_reg <= speed_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_reg <= ex_next;
        ey_reg <= ey_next;
        ez_reg <= ez_next;
        yaw_reg <= yaw_next;
        ang_reg <= ang_next;
        q_reg <= q_next;
        z_reg <= z_next;
        z2_reg <= z2_next;
        sn_reg <= sn_next;
        cs_reg <= cs_next;
        acc_reg <= acc_next;
        psi_reg <= psi_next;
        xr_reg <= xr_next;
        yr_reg <= yr_next;
        vdes_reg <= vdes_next;
        eh_reg <= eh_next;
        s_reg <= s_next;
        elev_res_reg <= elev_res_next;
        rud_res_reg <= rud_res_next;
        rpm_res_reg <= rpm_res_next;
        elev_out_reg <= elev_out_next;
        rud_out_reg <= rud_out_next;
        rpm_out_reg <= rpm_out_next;
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign elevator_cmd = elev_out_reg;
    assign rudder_cmd = rud_out_reg;
    assign propeller_rpm = rpm_out_reg;

    // An accepted transaction always starts the sine step.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_Z))
        else $error("accepted transaction did not start");

    a_loop_idx: assert property (@(posedge clk) disable iff (!rst_n)
        lp_reg != 2'd3)
        else $error("PID loop index out of range");

    a_sum_lim: assert property (@(posedge clk) disable iff (!rst_n)
        depth_sum_reg <= 32'(SUM_LIM) && depth_sum_reg >= -32'(SUM_LIM)
        && head_sum_reg <= 32'(SUM_LIM) && head_sum_reg >= -32'(SUM_LIM)
        && speed_sum_reg <= 32'(SUM_LIM) && speed_sum_reg >= -32'(SUM_LIM))
        else $error("integral outside its clamp");

    a_rpm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (rpm_out_reg >= 11'(RPM_MIN) && rpm_out_reg <= 11'(RPM_MAX)))
        else $error("propeller command outside its range");

endmodule

// File: verif/vehicle_depth_heading_speed_pid_tb.sv
// Self-checking testbench for the vehicle depth, heading and speed PID controller.
module vehicle_depth_heading_speed_pid_tb;
    import vdhs_pkg::*;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [15:0] yaw;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] dtgt;
        logic signed [31:0] xtgt;
        logic signed [31:0] ytgt;
    } nav_sample_t;

    typedef struct packed {
        logic signed [13:0] elev;
        logic signed [13:0] rud;
        logic [10:0]        rpm;
    } actuator_cmd_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [47:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    nav_sample_t cur_sample;
    logic out_valid;
    logic out_stall;
    logic signed [13:0] elevator_cmd;
    logic signed [13:0] rudder_cmd;
    logic [10:0] propeller_rpm;

    nav_sample_t pending_samples[$];
    actuator_cmd_t expected_cmds[$];
    logic [47:0] elev_gains, rud_gains, prop_gains;
    logic [31:0] guide_gains;
    longint depth_last, depth_sum, head_last, head_sum, speed_last, speed_sum;
    int mismatches;
    int checked;
    longint cycles;
    int burst_left;
    int gap_left;
    bit burst_mode;
    int stall_phase;

    vehicle_depth_heading_speed_pid i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .depth_now(cur_sample.depth),
        .yaw_now(cur_sample.yaw),
        .pos_x_now(cur_sample.px),
        .pos_y_now(cur_sample.py),
        .depth_target(cur_sample.dtgt),
        .pos_x_target(cur_sample.xtgt),
        .pos_y_target(cur_sample.ytgt),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .elevator_cmd(elevator_cmd),
        .rudder_cmd(rudder_cmd),
        .propeller_rpm(propeller_rpm)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint clamp32(longint v);
        return clamp(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint sine_q16(logic [15:0] ang);
        logic [1:0] quad;
        longint f, z, z2, inner, mid, s;
        quad = ang[15:14];
        f = ang[13:0];
        if (quad[0])
        begin
            f = 16384 - f;
        end
        z = f * 4;
        z2 = (z * z) >>> 16;
        inner = 42048 - ((4640 * z2) >>> 16);
        mid = 102944 - ((z2 * inner) >>> 16);
        s = (z * mid) >>> 16;
        return quad[1] ? -s : s;
    endfunction

    function automatic longint pid_update(longint e, logic [47:0] g, ref longint last,
                                          ref longint sum);
        longint s, o;
        s = clamp(sum + ((e * 3277) >>> 16), -327680, 327680);
        o = longint'(g[15:0]) * e + longint'(g[31:16]) * s
            + longint'(g[47:32]) * 20 * (e - last);
        sum = s;
        last = e;
        return o;
    endfunction

    function automatic actuator_cmd_t predict_commands(nav_sample_t n);
        longint sn, cs, psi, ex, ey, ez, xr, yr, vdes, psides, eh, oe, orud, op;
        actuator_cmd_t r;
        sn = sine_q16(n.yaw);
        cs = sine_q16(n.yaw + 16'h4000);
        psi = (longint'(n.yaw) * 205887) >>> 15;
        ex = clamp32(longint'(n.xtgt) - longint'(n.px));
        ey = clamp32(longint'(n.ytgt) - longint'(n.py));
        ez = clamp32(longint'(n.dtgt) - longint'(n.depth));
        xr = clamp32((ex * cs - ey * sn) >>> 16);
        yr = clamp32((ex * sn + ey * cs) >>> 16);
        if (xr < 0)
        begin
            xr = -xr;
        end
        vdes = clamp32((longint'(guide_gains[15:0]) * xr) >>> 8);
        psides = clamp32((longint'(guide_gains[31:16]) * yr) >>> 8);
        eh = clamp32(psides - psi);
        oe = pid_update(ez, elev_gains, depth_last, depth_sum);
        orud = pid_update(eh, rud_gains, head_last, head_sum);
        op = pid_update(vdes, prop_gains, speed_last, speed_sum);
        r.elev = 14'(clamp(-(oe >>> 16), -5120, 5120));
        r.rud = 14'(clamp(orud >>> 16, -5120, 5120));
        if (op < 0)
        begin
            op = -op;
        end
        r.rpm = 11'(clamp(op >>> 24, 400, 1500));
        return r;
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 200000)) - 100000);
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic nav_sample_t rand_sample();
        nav_sample_t n;
        n.depth = rand_pos();
        n.yaw = 16'($urandom);
        n.px = rand_pos();
        n.py = rand_pos();
        n.dtgt = rand_pos();
        n.xtgt = rand_pos();
        n.ytgt = rand_pos();
        return n;
    endfunction

    task automatic write_gain(cfg_idx_t idx, logic [47:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ELEVATOR: elev_gains = value;
            CFG_RUDDER: rud_gains = value;
            CFG_PROPELLER: prop_gains = value;
            default: guide_gains = value[31:0];
        endcase
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || expected_cmds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
    endtask

    task automatic run_random(int count);
        repeat (count) pending_samples.push_back(rand_sample());
        drain();
    endtask

    // Driver: bursts of transactions separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cur_sample <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_cmds.push_back(predict_commands(cur_sample));
                void'(pending_samples.pop_front());
            end
            if (in_valid && in_stall)
            begin
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_samples.size() != 0)
            begin
                in_valid <= 1'b1;
                cur_sample <= pending_samples[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern and result checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 500;
            out_stall <= (stall_phase < 250) ? 1'b0 : ($urandom_range(0, 3) == 0);
            if (out_valid && !out_stall)
            begin
                if (expected_cmds.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result: %0d %0d %0d", elevator_cmd, rudder_cmd,
                                 propeller_rpm);
                    end
                end
                else
                begin
                    actuator_cmd_t e;
                    e = expected_cmds.pop_front();
                    checked++;
                    if (e.elev !== elevator_cmd || e.rud !== rudder_cmd
                        || e.rpm !== propeller_rpm)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d: expected %0d %0d %0d, got %0d %0d %0d",
                                     checked, e.elev, e.rud, e.rpm, elevator_cmd, rudder_cmd,
                                     propeller_rpm);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("vehicle_depth_heading_speed_pid: mismatch");
            $finish;
        end
    end

    initial
    begin
        nav_sample_t n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ELEVATOR;
        cfg_wdata = '0;
        mismatches = 0;
        checked = 0;
        cycles = 0;
        elev_gains = ELEV_GAINS_RST;
        rud_gains = RUD_GAINS_RST;
        prop_gains = PROP_GAINS_RST;
        guide_gains = GUIDE_GAINS_RST;
        depth_last = 0;
        depth_sum = 0;
        head_last = 0;
        head_sum = 0;
        speed_last = 0;
        speed_sum = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        n = '0;
        pending_samples.push_back(n);
        n.dtgt = 32'sh7fffffff;
        n.depth = 32'sh80000000;
        pending_samples.push_back(n);
        n = '0;
        n.depth = 32'sh7fffffff;
        n.dtgt = 32'sh80000000;
        n.yaw = 16'sh7fff;
        pending_samples.push_back(n);
        n.yaw = 16'sh8000;
        n.xtgt = 32'sh7fffffff;
        n.px = 32'sh80000000;
        n.ytgt = 32'sh80000000;
        n.py = 32'sh7fffffff;
        pending_samples.push_back(n);
        n = '0;
        n.yaw = 16'sh4000;
        n.xtgt = 32'sh00050000;
        n.ytgt = 32'shfffb0000;
        pending_samples.push_back(n);
        n.yaw = 16'shc000;
        pending_samples.push_back(n);
        repeat (6) pending_samples.push_back(n);
        n = '1;
        pending_samples.push_back(n);
        n = '0;
        n.dtgt = 32'sh00100000;
        repeat (8) pending_samples.push_back(n);
        drain();
        run_random(150);

        write_gain(CFG_ELEVATOR, 48'hffff_ffff_ffff);
        write_gain(CFG_RUDDER, 48'hffff_ffff_ffff);
        write_gain(CFG_PROPELLER, 48'hffff_ffff_ffff);
        write_gain(CFG_GUIDANCE, 48'h0000_ffff_ffff);
        run_random(100);

        write_gain(CFG_ELEVATOR, 48'h0);
        write_gain(CFG_RUDDER, 48'h0);
        write_gain(CFG_PROPELLER, 48'h0);
        write_gain(CFG_GUIDANCE, 48'h0);
        run_random(80);

        write_gain(CFG_ELEVATOR, 48'h0);
        write_gain(CFG_RUDDER, 48'h0);
        write_gain(CFG_PROPELLER, 48'h0);
        write_gain(CFG_GUIDANCE, 48'h0);
        repeat (4)
        begin
            write_gain(CFG_ELEVATOR, {$urandom, $urandom});
            write_gain(CFG_RUDDER, {$urandom, $urandom});
            write_gain(CFG_PROPELLER, {$urandom, $urandom});
            write_gain(CFG_GUIDANCE, {16'h0, $urandom});
            run_random(70);
        end

        $display("Checked %0d commands over directed extremes and random samples,", checked);
        $display("with default, maximum, zero and random gain settings.");
        if (mismatches == 0)
        begin
            $display("vehicle_depth_heading_speed_pid: match");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("vehicle_depth_heading_speed_pid: mismatch");
        end
        $finish;
    end
endmodule

// File: vehicle_depth_heading_speed_pid.f
hw/rtl/vdhs_pkg.sv
hw/rtl/vdhs_mul.sv
hw/rtl/vehicle_depth_heading_speed_pid.sv
verif/vehicle_depth_heading_speed_pid_tb.sv
